// ----- hw/rtl/rv32asm_pkg.sv -----
// ----------------------------------------------------------------------------
// rv32asm_pkg
// Shared types, beats and mnemonic table for the RV32I text assembler.
// ----------------------------------------------------------------------------
package rv32asm_pkg;

	localparam int LINE_MAX       = 64;
	localparam int CNT_W          = $clog2(LINE_MAX + 1);
	localparam int MNEMONIC_CHARS = 6;
	localparam int NUM_MNEM       = 37;
	localparam int IDX_W          = $clog2(NUM_MNEM + 1);

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} char_beat_t;

	typedef struct packed {
		logic [31:0] instr_word;
		logic        mnemonic_known;
	} word_beat_t;

	typedef enum logic [2:0] {FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J} fmt_t;
	typedef enum logic [2:0] {T_RD, T_RS1, T_RS2, T_IMM, T_NONE} tgt_t;

	typedef struct packed {
		logic [0:5][7:0] text;   // padded with spaces, only len chars compared
		logic [2:0]      len;
		logic [6:0]      opcode;
		logic [2:0]      f3;
		logic [6:0]      f7;
		fmt_t            fmt;
		logic [2:0]      order;
		logic [1:0]      shift;  // 1: slli/srli, 2: srai
	} mnem_t;

	// completed line handed from parser to packer
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [4:0]       rd;
		logic [4:0]       rs1;
		logic [4:0]       rs2;
		logic [31:0]      imm;
		logic             pend;   // a number was still open at end of line
		logic [31:0]      acc;
		logic             neg;
		logic [1:0]       slot;
	} line_t;

	localparam mnem_t MNEM_TABLE [NUM_MNEM] = '{
		'{"lui   ", 3'd3, 7'd55,  3'd0, 7'd0,  FMT_U, 3'd0, 2'd0},
		'{"auipc ", 3'd6, 7'd23,  3'd0, 7'd0,  FMT_U, 3'd0, 2'd0},
		'{"jal   ", 3'd4, 7'd111, 3'd0, 7'd0,  FMT_J, 3'd0, 2'd0},
		'{"jalr  ", 3'd5, 7'd103, 3'd0, 7'd0,  FMT_I, 3'd1, 2'd0},
		'{"beq   ", 3'd4, 7'd99,  3'd0, 7'd0,  FMT_B, 3'd3, 2'd0},
		'{"bne   ", 3'd4, 7'd99,  3'd1, 7'd0,  FMT_B, 3'd3, 2'd0},
		'{"blt   ", 3'd4, 7'd99,  3'd4, 7'd0,  FMT_B, 3'd3, 2'd0},
		'{"bge   ", 3'd4, 7'd99,  3'd5, 7'd0,  FMT_B, 3'd3, 2'd0},
		'{"bltu  ", 3'd5, 7'd99,  3'd6, 7'd0,  FMT_B, 3'd3, 2'd0},
		'{"bgeu  ", 3'd5, 7'd99,  3'd7, 7'd0,  FMT_B, 3'd3, 2'd0},
		'{"lb    ", 3'd3, 7'd3,   3'd0, 7'd0,  FMT_I, 3'd1, 2'd0},
		'{"lh    ", 3'd3, 7'd3,   3'd1, 7'd0,  FMT_I, 3'd1, 2'd0},
		'{"lw    ", 3'd3, 7'd3,   3'd2, 7'd0,  FMT_I, 3'd1, 2'd0},
		'{"lbu   ", 3'd4, 7'd3,   3'd4, 7'd0,  FMT_I, 3'd1, 2'd0},
		'{"lhu   ", 3'd4, 7'd3,   3'd5, 7'd0,  FMT_I, 3'd1, 2'd0},
		'{"sb    ", 3'd3, 7'd35,  3'd0, 7'd0,  FMT_S, 3'd2, 2'd0},
		'{"sh    ", 3'd3, 7'd35,  3'd1, 7'd0,  FMT_S, 3'd2, 2'd0},
		'{"sw    ", 3'd3, 7'd35,  3'd2, 7'd0,  FMT_S, 3'd2, 2'd0},
		'{"addi  ", 3'd5, 7'd19,  3'd0, 7'd0,  FMT_I, 3'd4, 2'd0},
		'{"slti  ", 3'd5, 7'd19,  3'd2, 7'd0,  FMT_I, 3'd4, 2'd0},
		'{"sltiu ", 3'd6, 7'd19,  3'd3, 7'd0,  FMT_I, 3'd4, 2'd0},
		'{"xori  ", 3'd5, 7'd19,  3'd4, 7'd0,  FMT_I, 3'd4, 2'd0},
		'{"ori   ", 3'd4, 7'd19,  3'd6, 7'd0,  FMT_I, 3'd4, 2'd0},
		'{"andi  ", 3'd5, 7'd19,  3'd7, 7'd0,  FMT_I, 3'd4, 2'd0},
		'{"slli  ", 3'd5, 7'd19,  3'd1, 7'd0,  FMT_I, 3'd4, 2'd1},
		'{"srli  ", 3'd5, 7'd19,  3'd5, 7'd0,  FMT_I, 3'd4, 2'd1},
		'{"srai  ", 3'd5, 7'd19,  3'd5, 7'd32, FMT_I, 3'd4, 2'd2},
		'{"add   ", 3'd4, 7'd51,  3'd0, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"sub   ", 3'd4, 7'd51,  3'd0, 7'd32, FMT_R, 3'd5, 2'd0},
		'{"sll   ", 3'd4, 7'd51,  3'd1, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"slt   ", 3'd4, 7'd51,  3'd2, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"sltu  ", 3'd5, 7'd51,  3'd3, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"xor   ", 3'd4, 7'd51,  3'd4, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"srl   ", 3'd4, 7'd51,  3'd5, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"sra   ", 3'd4, 7'd51,  3'd5, 7'd32, FMT_R, 3'd5, 2'd0},
		'{"or    ", 3'd3, 7'd51,  3'd6, 7'd0,  FMT_R, 3'd5, 2'd0},
		'{"and   ", 3'd4, 7'd51,  3'd7, 7'd0,  FMT_R, 3'd5, 2'd0}
	};

	// operand held by a given slot of a given mnemonic
	function automatic tgt_t op_target(logic [IDX_W-1:0] idx, logic [1:0] slot);
		logic [2:0] ord;
		tgt_t       t;
		t = T_NONE;
		if (idx != '0 && idx <= IDX_W'(NUM_MNEM) && slot != 2'd3) begin
			ord = MNEM_TABLE[idx - IDX_W'(1)].order;
			case (ord)
				3'd0: t = (slot == 2'd0) ? T_RD  : (slot == 2'd1) ? T_IMM : T_NONE;
				3'd1: t = (slot == 2'd0) ? T_RD  : (slot == 2'd1) ? T_IMM : T_RS1;
				3'd2: t = (slot == 2'd0) ? T_RS2 : (slot == 2'd1) ? T_IMM : T_RS1;
				3'd3: t = (slot == 2'd0) ? T_RS1 : (slot == 2'd1) ? T_RS2 : T_IMM;
				3'd4: t = (slot == 2'd0) ? T_RD  : (slot == 2'd1) ? T_RS1 : T_IMM;
				3'd5: t = (slot == 2'd0) ? T_RD  : (slot == 2'd1) ? T_RS1 : T_RS2;
				default: t = T_NONE;
			endcase
		end
		return t;
	endfunction

endpackage

// ----- hw/rtl/rv32i_text_assembler.sv -----
// ----------------------------------------------------------------------------
// rv32i_text_assembler
// Streams one RV32I assembly line a character at a time, emits the word.
// ----------------------------------------------------------------------------
//  channel | valid/ready            | payload                      | dir
//  char    | char_valid/char_ready  | char_beat: char_byte, last   | in
//  word    | word_valid/word_ready  | word_beat: instr_word, known | out
//
//  One char beat per cycle, sustained. The beat carrying last_char passes
//  the input reg, the parser state/line reg and the result reg before its result appears.
//  Reset clears parser state to mnemonic collection; no clearing pass.
//  A stalled result freezes all stages; char_ready drops only then.
// ----------------------------------------------------------------------------
module rv32i_text_assembler (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	output logic                     char_ready,
	input  rv32asm_pkg::char_beat_t  char_beat,
	output logic                     word_valid,
	input  logic                     word_ready,
	output rv32asm_pkg::word_beat_t  word_beat
);
	import rv32asm_pkg::*;

	logic       adv;
	logic       char_valid_s1;
	char_beat_t char_s1;
	logic       line_valid_s2;
	line_t      line_s2;

	// whole pipe moves unless a finished word sits untaken
	assign adv        = !word_valid || word_ready;
	assign char_ready = adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (adv) begin
			char_valid_s1 <= char_valid;
			char_s1       <= char_beat;
		end
	end

	rv32asm_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.char_valid_s1 (char_valid_s1),
		.char_s1       (char_s1),
		.line_valid_s2 (line_valid_s2),
		.line_s2       (line_s2)
	);

	rv32asm_pack u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.line_valid_s2 (line_valid_s2),
		.line_s2       (line_s2),
		.word_valid_q  (word_valid),
		.word_q        (word_beat)
	);

endmodule

// ----- hw/rtl/rv32asm_parse.sv -----
// ----------------------------------------------------------------------------
// rv32asm_parse
// Per-character line parser: mnemonic match, operand scan, number accumulate.
// ----------------------------------------------------------------------------
module rv32asm_parse (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     char_valid_s1,
	input  rv32asm_pkg::char_beat_t  char_s1,
	output logic                     line_valid_s2,
	output rv32asm_pkg::line_t       line_s2
);
	import rv32asm_pkg::*;

	typedef enum logic [2:0] {
		PH_MNEM, PH_UNKNOWN, PH_SCAN_REG, PH_SCAN_IMM,
		PH_NUM_FIRST, PH_NUM_DIGITS, PH_DONE
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [0:5][7:0]  chars_q, chars_n, cand;
	logic [CNT_W-1:0] count_q, count_n;
	logic [1:0]       slot_q, slot_n;
	logic [31:0]      acc_q, acc_n;
	logic             neg_q, neg_n;
	logic [4:0]       rd_q, rd_n, rs1_q, rs1_n, rs2_q, rs2_n;
	logic [31:0]      imm_q, imm_n;
	logic [IDX_W-1:0] idx_q, idx_n, hit_idx;
	logic             hit, same, is_dig, fin;
	logic [7:0]       c;
	logic [31:0]      val;
	tgt_t             tgt;

	function automatic phase_t phase_for(tgt_t t);
		phase_t p;
		case (t)
			T_NONE:  p = PH_DONE;
			T_IMM:   p = PH_SCAN_IMM;
			default: p = PH_SCAN_REG;
		endcase
		return p;
	endfunction

	assign c      = char_s1.char_byte;
	assign is_dig = (c >= "0") && (c <= "9");

	// candidate mnemonic with the new char in place, and exact match against an entry of that length
	always_comb begin
		for (int k = 0; k < MNEMONIC_CHARS; k++)
			cand[k] = (CNT_W'(k) == count_q) ? c : chars_q[k];
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = NUM_MNEM - 1; i >= 0; i--) begin
			same = (CNT_W'(MNEM_TABLE[i].len) == count_q + CNT_W'(1));
			for (int k = 0; k < MNEMONIC_CHARS; k++)
				if (3'(k) < MNEM_TABLE[i].len && cand[k] != MNEM_TABLE[i].text[k])
					same = 1'b0;
			if (same) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i + 1);
			end
		end
	end

	always_comb begin
		phase_n = phase_q;
		chars_n = chars_q;
		count_n = count_q;
		slot_n  = slot_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		rd_n    = rd_q;
		rs1_n   = rs1_q;
		rs2_n   = rs2_q;
		imm_n   = imm_q;
		idx_n   = idx_q;
		fin     = 1'b0;
		tgt     = op_target(idx_q, slot_q);
		val     = neg_q ? (32'd0 - acc_q) : acc_q;
		if (count_q < CNT_W'(LINE_MAX)) begin
			count_n = count_q + CNT_W'(1);
			case (phase_q)
				PH_MNEM: begin
					if (count_q >= CNT_W'(MNEMONIC_CHARS)) begin
						phase_n = PH_UNKNOWN;
					end else begin
						chars_n = cand;
						if (hit) begin
							idx_n   = hit_idx;
							slot_n  = 2'd0;
							acc_n   = '0;
							neg_n   = 1'b0;
							phase_n = phase_for(op_target(hit_idx, 2'd0));
						end else if (count_q + CNT_W'(1) >= CNT_W'(MNEMONIC_CHARS)) begin
							phase_n = PH_UNKNOWN;
						end
					end
				end
				PH_SCAN_REG: begin
					if (c == "x") begin
						acc_n   = '0;
						neg_n   = 1'b0;
						phase_n = PH_NUM_FIRST;
					end
				end
				PH_NUM_FIRST, PH_SCAN_IMM: begin
					if (c == "-") begin
						neg_n   = 1'b1;
						phase_n = PH_NUM_DIGITS;
					end else if (is_dig) begin
						acc_n   = {28'd0, c[3:0]};
						phase_n = PH_NUM_DIGITS;
					end else if (phase_q == PH_NUM_FIRST) begin
						fin = 1'b1;
					end
				end
				PH_NUM_DIGITS: begin
					if (is_dig)
						acc_n = (acc_q << 3) + (acc_q << 1) + {28'd0, c[3:0]};
					else
						fin = 1'b1;
				end
				default: ;
			endcase
			if (fin) begin
				case (tgt)
					T_RD:    rd_n  = val[4:0];
					T_RS1:   rs1_n = val[4:0];
					T_RS2:   rs2_n = val[4:0];
					T_IMM:   imm_n = val;
					default: ;
				endcase
				slot_n  = slot_q + 2'd1;
				acc_n   = '0;
				neg_n   = 1'b0;
				phase_n = phase_for(op_target(idx_q, slot_q + 2'd1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MNEM;
			chars_q       <= '0;
			count_q       <= '0;
			slot_q        <= '0;
			acc_q         <= '0;
			neg_q         <= 1'b0;
			rd_q          <= '0;
			rs1_q         <= '0;
			rs2_q         <= '0;
			imm_q         <= '0;
			idx_q         <= '0;
			line_valid_s2 <= 1'b0;
		end else if (adv) begin
			line_valid_s2 <= char_valid_s1 && char_s1.last_char;
			line_s2       <= '{idx: idx_n, rd: rd_n, rs1: rs1_n, rs2: rs2_n, imm: imm_n,
				pend: (phase_n == PH_NUM_FIRST || phase_n == PH_NUM_DIGITS),
				acc: acc_n, neg: neg_n, slot: slot_n};
			if (char_valid_s1) begin
				if (char_s1.last_char) begin
					phase_q <= PH_MNEM;
					chars_q <= '0;
					count_q <= '0;
					slot_q  <= '0;
					acc_q   <= '0;
					neg_q   <= 1'b0;
					rd_q    <= '0;
					rs1_q   <= '0;
					rs2_q   <= '0;
					imm_q   <= '0;
					idx_q   <= '0;
				end else begin
					phase_q <= phase_n;
					chars_q <= chars_n;
					count_q <= count_n;
					slot_q  <= slot_n;
					acc_q   <= acc_n;
					neg_q   <= neg_n;
					rd_q    <= rd_n;
					rs1_q   <= rs1_n;
					rs2_q   <= rs2_n;
					imm_q   <= imm_n;
					idx_q   <= idx_n;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/rv32asm_pack.sv -----
// ----------------------------------------------------------------------------
// rv32asm_pack
// Closes any open number and packs the instruction word into the result reg.
// ----------------------------------------------------------------------------
module rv32asm_pack (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     line_valid_s2,
	input  rv32asm_pkg::line_t       line_s2,
	output logic                     word_valid_q,
	output rv32asm_pkg::word_beat_t  word_q
);
	import rv32asm_pkg::*;

	mnem_t       m;
	tgt_t        tgt;
	logic [31:0] val, imm, w;
	logic [4:0]  rd, rs1, rs2, mag;
	logic [11:0] i12, r12;
	logic        known;

	always_comb begin
		m     = MNEM_TABLE[(line_s2.idx != '0 && line_s2.idx <= IDX_W'(NUM_MNEM))
			? line_s2.idx - IDX_W'(1) : '0];
		known = (line_s2.idx != '0);
		tgt   = op_target(line_s2.idx, line_s2.slot);
		val   = line_s2.neg ? (32'd0 - line_s2.acc) : line_s2.acc;
		rd    = line_s2.rd;
		rs1   = line_s2.rs1;
		rs2   = line_s2.rs2;
		imm   = line_s2.imm;
		if (line_s2.pend) begin
			case (tgt)
				T_RD:    rd  = val[4:0];
				T_RS1:   rs1 = val[4:0];
				T_RS2:   rs2 = val[4:0];
				T_IMM:   imm = val;
				default: ;
			endcase
		end
		// truncated remainder by 32 for shift immediates, kept in 12 bits
		mag = imm[31] ? (5'd0 - imm[4:0]) : imm[4:0];
		r12 = imm[31] ? (12'd0 - {7'd0, mag}) : {7'd0, mag};
		if (m.shift == 2'd2)
			r12 = r12 + 12'd1024;
		i12 = (m.shift != 2'd0) ? r12 : imm[11:0];
		case (m.fmt)
			FMT_R:   w = {m.f7, rs2, rs1, m.f3, rd, m.opcode};
			FMT_I:   w = {i12, rs1, m.f3, rd, m.opcode};
			FMT_S:   w = {imm[11:5], rs2, rs1, m.f3, imm[4:0], m.opcode};
			FMT_B:   w = {imm[12], imm[10:5], rs2, rs1, m.f3, imm[4:1], imm[11], m.opcode};
			FMT_U:   w = {imm[19:0], rd, m.opcode};
			default: w = {imm[20], imm[10:1], imm[11], imm[19:12], rd, m.opcode};
		endcase
		if (!known)
			w = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (adv) begin
			word_valid_q <= line_valid_s2;
			word_q       <= '{instr_word: w, mnemonic_known: known};
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid_s2 && adv |=> word_valid_q)
		else $error("line beat lost on way to result register");
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid_q && !word_q.mnemonic_known |-> word_q.instr_word == 32'd0)
		else $error("unknown mnemonic with nonzero word");
	a_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid_q && word_q.mnemonic_known |-> word_q.instr_word[1:0] == 2'b11)
		else $error("known mnemonic without 32-bit opcode");

endmodule
